@@ rtl/core/ghc_pkg.sv @@
package ghc_pkg;

  // histogram geometry
  localparam int unsigned NUM_BINS    = 16384;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned BIN_AW      = $clog2(NUM_BINS);
  localparam int unsigned PTR_W       = BIN_AW + 1;

  // field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CHAN_W  = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned WBEG_W  = 14;
  localparam int unsigned WEND_W  = 15;
  localparam int unsigned TOT_W   = 46;
  localparam int unsigned FIX_W   = 22;
  localparam int unsigned FRAC_W  = 8;

  // datapath widths
  localparam int unsigned PROD_W  = COUNT_WIDTH + BIN_AW;
  localparam int unsigned XS_W    = PROD_W + BIN_AW;
  localparam int unsigned NUM_W   = XS_W + FRAC_W;
  localparam int unsigned DEV2_W  = 2 * FIX_W;
  localparam int unsigned HALF_W  = FIX_W;
  localparam int unsigned PP_W    = COUNT_WIDTH + HALF_W;
  localparam int unsigned DSUM_W  = COUNT_WIDTH + DEV2_W + BIN_AW;
  localparam int unsigned ROOT_W  = (DSUM_W + 1) / 2;
  localparam int unsigned DIV_CW  = $clog2(NUM_W + 1);
  localparam int unsigned SQRT_CW = $clog2(ROOT_W + 1);

  // opcodes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_STAT   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_WIN_BEGIN = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_WIN_END   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_GATE_LOW  = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_GATE_HIGH = 2'd3;

  localparam logic [WBEG_W-1:0] WIN_BEGIN_RST = 14'd2000;
  localparam logic [WEND_W-1:0] WIN_END_RST   = 15'd5000;
  localparam logic [TIME_W-1:0] GATE_LOW_RST  = 32'd3500000;
  localparam logic [TIME_W-1:0] GATE_HIGH_RST = 32'd8800000;

  typedef enum logic [2:0] {
    CMD_INS  = 3'b001,
    CMD_STAT = 3'b010,
    CMD_CLR  = 3'b100
  } ghc_cmd_e;

  typedef struct packed {
    ghc_cmd_e            kind;
    logic [BIN_AW-1:0]   bin;
  } ghc_cmd_t;

  typedef struct packed {
    logic [WBEG_W-1:0] window_begin;
    logic [WEND_W-1:0] window_end;
    logic [TIME_W-1:0] gate_low;
    logic [TIME_W-1:0] gate_high;
  } ghc_cfg_t;

endpackage

@@ rtl/core/ghc_front.sv @@
module ghc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ghc_pkg::OP_W-1:0]     opcode_i,
  input  logic [ghc_pkg::CHAN_W-1:0]   energy_channel_i,
  input  logic [ghc_pkg::TIME_W-1:0]   time_stamp_i,
  input  ghc_pkg::ghc_cfg_t            cfg_i,
  input  logic                         init_done_i,
  output logic                         cmd_valid_o,
  input  logic                         cmd_ready_i,
  output ghc_pkg::ghc_cmd_t            cmd_o
);
  import ghc_pkg::*;

  ghc_cmd_t   fifo_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       accept, keep, pop;
  ghc_cmd_t   cls;

  // classify: dropped inserts and unused opcodes never reach the queue
  always_comb begin
    keep     = 1'b0;
    cls.kind = CMD_INS;
    cls.bin  = energy_channel_i[BIN_AW-1:0];
    unique case (opcode_i)
      OP_INSERT: begin
        keep = ({1'b0, energy_channel_i} < (CHAN_W+1)'(NUM_BINS))
            && (time_stamp_i > cfg_i.gate_low) && (time_stamp_i < cfg_i.gate_high);
      end
      OP_STAT: begin
        keep     = 1'b1;
        cls.kind = CMD_STAT;
      end
      OP_CLEAR: begin
        keep     = 1'b1;
        cls.kind = CMD_CLR;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o  = init_done_i && (cnt_q != 2'd2);
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_q];
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (accept && keep) cnt_d = cnt_d + 2'd1;
    if (pop)            cnt_d = cnt_d - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (accept && keep) wr_q <= ~wr_q;
      if (pop)            rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && keep) fifo_q[wr_q] <= cls;
  end

endmodule

@@ rtl/core/ghc_div.sv @@
module ghc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ghc_pkg::NUM_W-1:0]   num_i,
  input  logic [ghc_pkg::TOT_W-1:0]   den_i,
  output logic                        done_o,
  output logic [ghc_pkg::FIX_W-1:0]   quot_o
);
  import ghc_pkg::*;

  logic              busy_q, done_q, ovf_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [NUM_W-1:0]  n_q;
  logic [TOT_W-1:0]  rem_q;
  logic [FIX_W-1:0]  q_q;
  logic [TOT_W:0]    sh, diff;
  logic              ge;

  // restoring division, one quotient bit a cycle
  assign sh   = {rem_q, n_q[NUM_W-1]};
  assign ge   = (sh >= {1'b0, den_i});
  assign diff = sh - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CW'(1);
        if (cnt_q == DIV_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      rem_q <= '0;
      q_q   <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      n_q   <= {n_q[NUM_W-2:0], 1'b0};
      rem_q <= ge ? diff[TOT_W-1:0] : sh[TOT_W-1:0];
      ovf_q <= ovf_q | q_q[FIX_W-1];
      q_q   <= {q_q[FIX_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = ovf_q ? '1 : q_q;

endmodule

@@ rtl/core/ghc_sqrt.sv @@
module ghc_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ghc_pkg::DSUM_W-1:0]   rad_i,
  output logic                         done_o,
  output logic [ghc_pkg::ROOT_W-1:0]   root_o
);
  import ghc_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 3;
  localparam int unsigned X_W   = 2 * ROOT_W;

  logic               busy_q, done_q;
  logic [SQRT_CW-1:0] cnt_q;
  logic [X_W-1:0]     x_q;
  logic [REM_W-1:0]   rem_q, sh, trial;
  logic [ROOT_W-1:0]  root_q;
  logic               ge;

  // digit-by-digit root, one result bit a cycle
  assign sh    = {rem_q[REM_W-3:0], x_q[X_W-1:X_W-2]};
  assign trial = REM_W'({root_q, 2'b01});
  assign ge    = (sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= SQRT_CW'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - SQRT_CW'(1);
        if (cnt_q == SQRT_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= X_W'(rad_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[X_W-3:0], 2'b00};
      rem_q  <= ge ? (sh - trial) : sh;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ rtl/core/ghc_back.sv @@
module ghc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ghc_pkg::ghc_cfg_t            cfg_i,
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  ghc_pkg::ghc_cmd_t            cmd_i,
  output logic                         init_done_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ghc_pkg::TOT_W-1:0]    total_count_o,
  output logic [ghc_pkg::FIX_W-1:0]    centroid_o,
  output logic [ghc_pkg::FIX_W-1:0]    spread_o,
  output logic                         empty_res_o
);
  import ghc_pkg::*;

  typedef enum logic [9:0] {
    S_CLR    = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_INS_RD = 10'b0000000100,
    S_INS_WR = 10'b0000001000,
    S_WIN    = 10'b0000010000,
    S_P1     = 10'b0000100000,
    S_DIVC   = 10'b0001000000,
    S_P2     = 10'b0010000000,
    S_SQRT   = 10'b0100000000,
    S_DIVS   = 10'b1000000000
  } ghc_state_e;

  ghc_state_e state_q, state_d;

  // bin store
  logic [COUNT_WIDTH-1:0] bins_q [NUM_BINS];
  logic [COUNT_WIDTH-1:0] rdata_q, wdata;
  logic                   re, we;
  logic [BIN_AW-1:0]      raddr, waddr;

  logic [PTR_W-1:0]  ptr_q, ptr_d, beg_q, beg_d, end_q, end_d;
  logic [BIN_AW-1:0] bin_q, bin_d;
  logic              init_done_q, init_done_d;

  // walk pipeline
  logic                   p1v_q, p1v_d, p2v_q, p3v_q;
  logic [BIN_AW-1:0]      p1i_q;
  logic [FIX_W-1:0]       dev_q, dev_d, pos;
  logic [COUNT_WIDTH-1:0] c2_q;
  logic [PROD_W-1:0]      prod_q;
  logic [DEV2_W-1:0]      dev2_q;
  logic [PP_W-1:0]        plo_q, phi_q;

  logic [TOT_W-1:0]  total_q, total_d;
  logic [XS_W-1:0]   xs_q, xs_d;
  logic [DSUM_W-1:0] dsum_q, dsum_d;
  logic [FIX_W-1:0]  cen_q, cen_d;

  logic              out_valid_q, out_valid_d, empty_q, empty_d;
  logic [TOT_W-1:0]  out_total_q, out_total_d;
  logic [FIX_W-1:0]  out_cen_q, out_cen_d, out_spr_q, out_spr_d;

  logic              div_start, div_done, sqrt_start, sqrt_done;
  logic [NUM_W-1:0]  div_num;
  logic [FIX_W-1:0]  div_quot;
  logic [ROOT_W-1:0] root;

  logic [PTR_W-1:0]  wbeg, wend;
  logic              issue_left;

  assign wbeg       = PTR_W'(cfg_i.window_begin);
  assign wend       = PTR_W'(cfg_i.window_end);
  assign issue_left = (ptr_q != end_q);
  assign pos        = FIX_W'({ptr_q[BIN_AW-1:0], {FRAC_W{1'b0}}});
  assign dev_d      = (cen_q >= pos) ? (cen_q - pos) : (pos - cen_q);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    beg_d       = beg_q;
    end_d       = end_q;
    bin_d       = bin_q;
    init_done_d = init_done_q;
    total_d     = total_q;
    xs_d        = xs_q;
    dsum_d      = dsum_q;
    cen_d       = cen_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_total_d = out_total_q;
    out_cen_d   = out_cen_q;
    out_spr_d   = out_spr_q;
    empty_d     = empty_q;
    re          = 1'b0;
    raddr       = ptr_q[BIN_AW-1:0];
    we          = 1'b0;
    waddr       = ptr_q[BIN_AW-1:0];
    wdata       = '0;
    p1v_d       = 1'b0;
    cmd_ready_o = 1'b0;
    div_start   = 1'b0;
    div_num     = {xs_q, {FRAC_W{1'b0}}};
    sqrt_start  = 1'b0;

    unique case (state_q)
      S_CLR: begin
        we    = 1'b1;
        ptr_d = ptr_q + PTR_W'(1);
        if (ptr_q == PTR_W'(NUM_BINS - 1)) begin
          init_done_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_ready_o = (cmd_i.kind != CMD_STAT) || !out_valid_q;
        if (cmd_valid_i && cmd_ready_o) begin
          unique case (cmd_i.kind)
            CMD_INS: begin
              bin_d   = cmd_i.bin;
              state_d = S_INS_RD;
            end
            CMD_CLR: begin
              ptr_d   = '0;
              state_d = S_CLR;
            end
            CMD_STAT: state_d = S_WIN;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_INS_RD: begin
        re      = 1'b1;
        raddr   = bin_q;
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        waddr   = bin_q;
        wdata   = rdata_q + COUNT_WIDTH'(1);
        we      = (rdata_q != '1);
        state_d = S_IDLE;
      end
      S_WIN: begin
        if (wbeg >= PTR_W'(NUM_BINS)) begin
          out_valid_d = 1'b1;
          out_total_d = '0;
          out_cen_d   = '0;
          out_spr_d   = '0;
          empty_d     = 1'b1;
          state_d     = S_IDLE;
        end else begin
          beg_d   = wbeg;
          ptr_d   = wbeg;
          end_d   = ((wend < wbeg) || (wend > PTR_W'(NUM_BINS))) ? PTR_W'(NUM_BINS) : wend;
          total_d = '0;
          xs_d    = '0;
          state_d = S_P1;
        end
      end
      S_P1: begin
        if (issue_left) begin
          re    = 1'b1;
          p1v_d = 1'b1;
          ptr_d = ptr_q + PTR_W'(1);
        end
        if (p2v_q) begin
          total_d = total_q + TOT_W'(c2_q);
          xs_d    = xs_q + XS_W'(prod_q);
        end
        if (!issue_left && !p1v_q && !p2v_q) begin
          if (total_q == '0) begin
            out_valid_d = 1'b1;
            out_total_d = '0;
            out_cen_d   = '0;
            out_spr_d   = '0;
            empty_d     = 1'b1;
            state_d     = S_IDLE;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIVC;
          end
        end
      end
      S_DIVC: begin
        if (div_done) begin
          cen_d   = div_quot;
          ptr_d   = beg_q;
          dsum_d  = '0;
          state_d = S_P2;
        end
      end
      S_P2: begin
        if (issue_left) begin
          re    = 1'b1;
          p1v_d = 1'b1;
          ptr_d = ptr_q + PTR_W'(1);
        end
        if (p3v_q) begin
          dsum_d = dsum_q + DSUM_W'(plo_q) + (DSUM_W'(phi_q) << HALF_W);
        end
        if (!issue_left && !p1v_q && !p2v_q && !p3v_q) begin
          sqrt_start = 1'b1;
          state_d    = S_SQRT;
        end
      end
      S_SQRT: begin
        div_num = NUM_W'(root);
        if (sqrt_done) begin
          div_start = 1'b1;
          state_d   = S_DIVS;
        end
      end
      S_DIVS: begin
        if (div_done) begin
          out_valid_d = 1'b1;
          out_total_d = total_q;
          out_cen_d   = cen_q;
          out_spr_d   = div_quot;
          empty_d     = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      ptr_q       <= '0;
      init_done_q <= 1'b0;
      out_valid_q <= 1'b0;
      p1v_q       <= 1'b0;
      p2v_q       <= 1'b0;
      p3v_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      init_done_q <= init_done_d;
      out_valid_q <= out_valid_d;
      p1v_q       <= p1v_d;
      p2v_q       <= p1v_q;
      p3v_q       <= p2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    beg_q       <= beg_d;
    end_q       <= end_d;
    bin_q       <= bin_d;
    total_q     <= total_d;
    xs_q        <= xs_d;
    dsum_q      <= dsum_d;
    cen_q       <= cen_d;
    out_total_q <= out_total_d;
    out_cen_q   <= out_cen_d;
    out_spr_q   <= out_spr_d;
    empty_q     <= empty_d;
    p1i_q       <= ptr_q[BIN_AW-1:0];
    dev_q       <= dev_d;
    c2_q        <= rdata_q;
    prod_q      <= PROD_W'(rdata_q) * PROD_W'(p1i_q);
    dev2_q      <= DEV2_W'(dev_q) * DEV2_W'(dev_q);
    plo_q       <= PP_W'(c2_q) * PP_W'(dev2_q[HALF_W-1:0]);
    phi_q       <= PP_W'(c2_q) * PP_W'(dev2_q[DEV2_W-1:HALF_W]);
  end

  always_ff @(posedge clk_i) begin
    if (we) bins_q[waddr] <= wdata;
    if (re) rdata_q <= bins_q[raddr];
  end

  ghc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (total_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  ghc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (dsum_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign init_done_o   = init_done_q;
  assign out_valid_o   = out_valid_q;
  assign total_count_o = out_total_q;
  assign centroid_o    = out_cen_q;
  assign spread_o      = out_spr_q;
  assign empty_res_o   = empty_q;

endmodule

@@ rtl/core/gated_histogram_centroid.sv @@
// Insert: taken into the front queue; the back takes each one through take, read and
//   write back, and takes no new command before the write back is done.
// Clear: taken, then one bin written per cycle across all 16384 bins.
// Stat: for a window of W bins, a first walk, the divider for the centroid, a second walk,
//   the square root and the divider for the spread; a zero total ends after the first walk.
// Reset: control cleared, config at reset values; clears all 16384 bins, in_ready_o low.
module gated_histogram_centroid (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ghc_pkg::OP_W-1:0]      opcode_i,
  input  logic [ghc_pkg::CHAN_W-1:0]    energy_channel_i,
  input  logic [ghc_pkg::TIME_W-1:0]    time_stamp_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ghc_pkg::TOT_W-1:0]     total_count_o,
  output logic [ghc_pkg::FIX_W-1:0]     centroid_o,
  output logic [ghc_pkg::FIX_W-1:0]     spread_o,
  output logic                          empty_res_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ghc_pkg::CIDX_W-1:0]    cfg_index_i,
  input  logic [ghc_pkg::CFG_W-1:0]     cfg_data_i
);
  import ghc_pkg::*;

  ghc_cfg_t cfg_q;
  ghc_cmd_t cmd;
  logic     cmd_valid, cmd_ready, init_done;

  // cfg writes always taken, user keeps them only done while block is idle, not enforced
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_begin <= WIN_BEGIN_RST;
      cfg_q.window_end   <= WIN_END_RST;
      cfg_q.gate_low     <= GATE_LOW_RST;
      cfg_q.gate_high    <= GATE_HIGH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WIN_BEGIN: cfg_q.window_begin <= cfg_data_i[WBEG_W-1:0];
        CFG_WIN_END:   cfg_q.window_end   <= cfg_data_i[WEND_W-1:0];
        CFG_GATE_LOW:  cfg_q.gate_low     <= cfg_data_i[TIME_W-1:0];
        CFG_GATE_HIGH: cfg_q.gate_high    <= cfg_data_i[TIME_W-1:0];
        default:       cfg_q              <= cfg_q;
      endcase
    end
  end

  // front: takes each transaction, applies channel range and time gate,
  // queues the surviving commands (two deep)
  ghc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .energy_channel_i (energy_channel_i),
    .time_stamp_i     (time_stamp_i),
    .cfg_i            (cfg_q),
    .init_done_i      (init_done),
    .cmd_valid_o      (cmd_valid),
    .cmd_ready_i      (cmd_ready),
    .cmd_o            (cmd)
  );

  // back: bin memory, clear sweep, saturating increment and the window
  // statistics sequencer with its result register
  ghc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .init_done_o   (init_done),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .total_count_o (total_count_o),
    .centroid_o    (centroid_o),
    .spread_o      (spread_o),
    .empty_res_o   (empty_res_o)
  );

endmodule
